// ----- rtl/packed_record_deframer_top_macros.svh -----
// Assertion macros used by the file that checks the packed record deframer.
`ifndef PACKED_RECORD_DEFRAMER_TOP_MACROS_SVH
`define PACKED_RECORD_DEFRAMER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PKD_ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("packed record deframer check failed");

// Implication checked from one clock edge to the next.
`define PKD_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("packed record deframer check failed");

`endif

// ----- rtl/pkd_pkg.sv -----
// Package with the types and field widths shared by the deframer modules.
`default_nettype none

package pkd_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned LenW  = 8;

  // One payload word on its way from the parser to the output side.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [WordW-1:0] address;
    logic [LenW-1:0]  length;
    logic [LenW-1:0]  position;
    logic             end_of_slice;
  } pkd_item_t;

  // Write side of the item queue.
  typedef struct packed {
    logic      valid;
    pkd_item_t item;
  } pkd_wr_t;

  // Fill status of the item queue.
  typedef struct packed {
    logic full;
    logic empty;
  } pkd_qstat_t;

endpackage

`default_nettype wire

// ----- rtl/pkd_front.sv -----
// Front part: accepts microslice words, tracks the record structure, forwards payload words.
`default_nettype none

module pkd_front import pkd_pkg::*; #(
  parameter int unsigned DESCRIPTOR_WORDS = 8,
  parameter int unsigned ALIGN_WORDS      = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  input  wire logic             full,
  input  wire logic [WordW-1:0] word_i,
  input  wire logic             end_of_slice_i,
  output pkd_wr_t               wr_o
);

  localparam int unsigned AlignW = (ALIGN_WORDS > 1) ? $clog2(ALIGN_WORDS) : 1;
  localparam logic [AlignW-1:0] AlignLast = AlignW'(ALIGN_WORDS - 1);
  localparam logic [LenW-1:0]   DescCount = LenW'(DESCRIPTOR_WORDS);

  localparam logic [2:0] PhDesc    = 3'd0;
  localparam logic [2:0] PhHeader  = 3'd1;
  localparam logic [2:0] PhAddress = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhPad     = 3'd4;

  localparam logic [2:0] PhStart = (DESCRIPTOR_WORDS == 0) ? PhHeader : PhDesc;

  logic [2:0]        phase_q, phase_d;
  logic [LenW-1:0]   counter_q, counter_d;
  logic [WordW-1:0]  addr_q, addr_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [AlignW-1:0] align_q, align_d;

  logic            accept;
  logic [LenW-1:0] count_next;
  logic [LenW-1:0] desc_base;
  logic            last_word;

  // Step the alignment position, wrapping at the alignment size.
  function automatic logic [AlignW-1:0] align_next(input logic [AlignW-1:0] p);
    logic [AlignW-1:0] r;
    if (p == AlignLast) begin
      r = '0;
    end else begin
      r = p + AlignW'(1);
    end
    return r;
  endfunction

  assign accept     = push && !full;
  assign count_next = counter_q + LenW'(1);
  assign last_word  = (count_next == len_q);
  assign desc_base  = (phase_q == PhDesc) ? counter_q : '0;

  // Parser state update for each accepted word.
  always_comb begin
    phase_d   = phase_q;
    counter_d = counter_q;
    addr_d    = addr_q;
    len_d     = len_q;
    align_d   = align_q;
    if (accept) begin
      unique case (phase_q)
        PhHeader: begin
          len_d   = word_i[LenW-1:0];
          align_d = align_next('0);
          phase_d = PhAddress;
        end
        PhAddress: begin
          align_d = align_next(align_q);
          if (len_q != '0) begin
            addr_d    = word_i;
            counter_d = '0;
            phase_d   = PhPayload;
          end else begin
            phase_d = (align_next(align_q) == '0) ? PhHeader : PhPad;
          end
        end
        PhPayload: begin
          align_d   = align_next(align_q);
          counter_d = count_next;
          if (last_word) begin
            phase_d = (align_next(align_q) == '0) ? PhHeader : PhPad;
          end
        end
        PhPad: begin
          align_d = align_next(align_q);
          if (align_next(align_q) == '0) begin
            phase_d = PhHeader;
          end
        end
        default: begin
          // Descriptor skip; unused codes restart the count from zero.
          counter_d = desc_base + LenW'(1);
          phase_d   = PhDesc;
          if ((desc_base + LenW'(1)) >= DescCount) begin
            counter_d = '0;
            align_d   = '0;
            phase_d   = PhHeader;
          end
        end
      endcase
      // The end of a slice on an accepted word returns the parser to its start phase.
      if (end_of_slice_i) begin
        counter_d = '0;
        align_d   = '0;
        phase_d   = PhStart;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhStart;
      counter_q <= '0;
      addr_q    <= '0;
      len_q     <= '0;
      align_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      counter_q <= counter_d;
      addr_q    <= addr_d;
      len_q     <= len_d;
      align_q   <= align_d;
    end
  end

  // Payload words go to the queue together with their record context.
  always_comb begin
    wr_o.valid             = accept && (phase_q == PhPayload);
    wr_o.item.word         = word_i;
    wr_o.item.address      = addr_q;
    wr_o.item.length       = len_q;
    wr_o.item.position     = counter_q;
    wr_o.item.end_of_slice = end_of_slice_i;
  end

endmodule

`default_nettype wire

// ----- rtl/pkd_queue.sv -----
// Short queue that decouples the parser from the result side.
`default_nettype none

module pkd_queue import pkd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire pkd_wr_t wr_i,
  input  wire logic    pop,
  output pkd_item_t    head_o,
  output pkd_qstat_t   stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  pkd_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign stat_o = '{full: (count_q == CntFull), empty: (count_q == '0)};
  assign do_pop = pop && !stat_o.empty;
  assign head_o = mem_q[rd_ptr_q];

  // Entry storage; the front only writes while the queue has room.
  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      mem_q[wr_ptr_q] <= wr_i.item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_i.valid && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!wr_i.valid && do_pop) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pkd_back.sv -----
// Back part: turns the oldest queued payload word into a result with its flags.
`default_nettype none

module pkd_back import pkd_pkg::*; (
  input  wire pkd_item_t         head_i,
  output logic [WordW-1:0]       payload_word_o,
  output logic [WordW-1:0]       record_address_o,
  output logic [LenW-1:0]        record_length_o,
  output logic [LenW-1:0]        word_position_o,
  output logic                   last_of_record_o,
  output logic                   truncated_o
);

  logic last;

  // The final word of a record is the one whose position is one below the length.
  assign last = ((head_i.position + LenW'(1)) == head_i.length);

  assign payload_word_o   = head_i.word;
  assign record_address_o = head_i.address;
  assign record_length_o  = head_i.length;
  assign word_position_o  = head_i.position;
  assign last_of_record_o = last;
  assign truncated_o      = head_i.end_of_slice && !last;

endmodule

`default_nettype wire

// ----- rtl/packed_record_deframer_top.sv -----
// Top level of the packed record deframer: parser, item queue and result side.
//
//   channel  direction  handshake          payload
//   words    in         push / full        word_i, end_of_slice_i
//   results  out        pop / empty        payload_word_o .. truncated_o
//
// One word is accepted per cycle while full is low, whatever its word type.
// A payload word is registered in the queue and reaches the result ports once older words are popped.
// The queue of QUEUE_DEPTH entries sets how long the result side may stall before
// full rises; full depends only on the queue fill, not on pop in the same cycle.
// Reset empties the queue and puts the parser in PhStart: descriptor skip or header.
`default_nettype none

module packed_record_deframer_top import pkd_pkg::*; #(
  parameter int unsigned DESCRIPTOR_WORDS = 8,
  parameter int unsigned ALIGN_WORDS      = 4,
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WordW-1:0] word_i,
  input  wire logic             end_of_slice_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic [WordW-1:0]      payload_word_o,
  output logic [WordW-1:0]      record_address_o,
  output logic [LenW-1:0]       record_length_o,
  output logic [LenW-1:0]       word_position_o,
  output logic                  last_of_record_o,
  output logic                  truncated_o
);

  pkd_wr_t    wr;
  pkd_item_t  head;
  pkd_qstat_t qstat;

  assign full  = qstat.full;
  assign empty = qstat.empty;

  // Record parser.
  pkd_front #(
    .DESCRIPTOR_WORDS(DESCRIPTOR_WORDS),
    .ALIGN_WORDS     (ALIGN_WORDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (qstat.full),
    .word_i        (word_i),
    .end_of_slice_i(end_of_slice_i),
    .wr_o          (wr)
  );

  // Queue between parser and result side.
  pkd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (wr),
    .pop   (pop),
    .head_o(head),
    .stat_o(qstat)
  );

  // Result formatting.
  pkd_back u_back (
    .head_i          (head),
    .payload_word_o  (payload_word_o),
    .record_address_o(record_address_o),
    .record_length_o (record_length_o),
    .word_position_o (word_position_o),
    .last_of_record_o(last_of_record_o),
    .truncated_o     (truncated_o)
  );

endmodule

`default_nettype wire

// ----- rtl/pkd_checker.sv -----
// Port-level checker for the packed record deframer and its bind statement.
`default_nettype none

`include "packed_record_deframer_top_macros.svh"

module pkd_checker import pkd_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             full,
  input wire logic             empty,
  input wire logic             pop,
  input wire logic [WordW-1:0] payload_word_o,
  input wire logic [WordW-1:0] record_address_o,
  input wire logic [LenW-1:0]  record_length_o,
  input wire logic [LenW-1:0]  word_position_o,
  input wire logic             last_of_record_o,
  input wire logic             truncated_o
);

  logic [2*WordW+2*LenW+1:0] result_bits;
  logic                      last_expected;

  // All result fields together, and the last flag that the position implies.
  assign result_bits   = {payload_word_o, record_address_o, record_length_o,
                          word_position_o, last_of_record_o, truncated_o};
  assign last_expected = ((word_position_o + LenW'(1)) == record_length_o);

  // A result that is not taken stays unchanged.
  `PKD_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_bits))

  // A truncated word is never the final word of its record.
  `PKD_ASSERT_HOLDS(a_flags_exclusive, clk_i, rst_ni, empty || !(last_of_record_o && truncated_o))

  // Every result lies inside a record of nonzero length.
  `PKD_ASSERT_HOLDS(a_position_in_range, clk_i, rst_ni, empty || (word_position_o < record_length_o))

  // The last flag marks exactly the word one below the length.
  `PKD_ASSERT_HOLDS(a_last_matches, clk_i, rst_ni, empty || (last_of_record_o == last_expected))

  // A full block always has a result waiting.
  `PKD_ASSERT_HOLDS(a_full_not_empty, clk_i, rst_ni, !(full && empty))

endmodule

bind packed_record_deframer_top pkd_checker u_checker (.*);

`default_nettype wire
